### hw/rtl/stq_pkg.sv
// types, codes and the wraparound deadline compare shared by the timeout queue
package stq_pkg;

  localparam logic [31:0] TIME_HALF = 32'h7fff_ffff;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [31:0] deadline;
    logic [15:0] handler;
    logic [31:0] argument;
  } stq_entry_t;

  localparam stq_entry_t EMPTY_ENTRY = '0;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t   cmd;
    logic [31:0] deadline;
    logic [15:0] handler;
    logic [31:0] argument;
  } stq_ctrl_t;

  function automatic logic is_earlier(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff > TIME_HALF;
  endfunction

endpackage

### hw/rtl/stq_cell.sv
// one slot of the sorted chain: holds an entry, shifts toward either neighbor
module stq_cell (
  input  logic               clk,
  input  logic               rst,
  input  stq_pkg::stq_ctrl_t  ctrl,
  input  stq_pkg::stq_entry_t left,
  input  stq_pkg::stq_entry_t right,
  input  logic               found_in,
  output logic               found_out,
  output stq_pkg::stq_entry_t entry
);
  import stq_pkg::*;

  logic        valid;
  logic [31:0] deadline;
  logic [15:0] handler;
  logic [31:0] argument;
  logic        hit;
  stq_entry_t  entry_next;

  assign entry = '{valid: valid, deadline: deadline, handler: handler, argument: argument};

  // first hit along the chain marks the insert or removal point
  always_comb begin
    case (ctrl.cmd)
      CELL_INSERT: hit = !valid || is_earlier(ctrl.deadline, deadline);
      CELL_REMOVE: hit = valid && handler == ctrl.handler && argument == ctrl.argument;
      default:     hit = 1'b0;
    endcase
  end

  assign found_out = found_in | hit;

  always_comb begin
    entry_next = entry;
    case (ctrl.cmd)
      CELL_INSERT: begin
        if (found_in) begin
          entry_next = left;
        end else if (hit) begin
          entry_next = '{valid: 1'b1, deadline: ctrl.deadline, handler: ctrl.handler,
                         argument: ctrl.argument};
        end
      end
      CELL_REMOVE: begin
        if (found_out) begin
          entry_next = right;
        end
      end
      CELL_POP: entry_next = right;
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= entry_next.valid;
    end
    deadline <= entry_next.deadline;
    handler  <= entry_next.handler;
    argument <= entry_next.argument;
  end

endmodule

### hw/rtl/sorted_timeout_queue.sv
// top level of the sorted timeout queue: command sequencer over a chain of slot cells
//
//   channel   direction  handshake                     payload
//   command   in         start & !busy = transfer      operation now delay_ms handler_id argument
//   result    out        result_valid, one cycle each  status expired_handler expired_argument last
//
// start, cancel and the unused code: the command and now + delay_ms are registered at
// the transfer edge; any chain shift happens on the edge that registers the answer, and
// busy falls with that answer
// check: due head entries are popped in turn, each one with a callback giving an expired
// result, then the done result; the head cell is compared against now once per cycle
// reset clears the slot valid bits and the sequencer directly, no clearing pass
// the receiver cannot stall: each result is shown for one cycle and busy falls with the
// last one, so a new command may transfer while that last result is on the ports
module sorted_timeout_queue #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] now,
  input  logic [31:0] delay_ms,
  input  logic [15:0] handler_id,
  input  logic [31:0] argument,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [15:0] expired_handler,
  output logic [31:0] expired_argument,
  output logic        last
);
  import stq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CANCEL,
    S_CHECK,
    S_OTHER
  } state_t;

  state_t state;

  // command fields held for the whole operation
  logic [31:0] key_deadline;
  logic [31:0] key_now;
  logic [15:0] key_handler;
  logic [31:0] key_argument;

  stq_ctrl_t  ctrl;
  stq_entry_t chain [ENTRIES];
  logic [ENTRIES:0]   found;
  logic [ENTRIES-1:0] valid_vec;
  logic full;
  logic head_due;

  assign busy = state != S_IDLE;
  assign found[0] = 1'b0;

  // table is full when the tail slot is occupied, valid slots form a prefix
  assign full = chain[ENTRIES-1].valid;
  // the head holds the earliest deadline; due once now is not earlier than it
  assign head_due = chain[0].valid && !is_earlier(key_now, chain[0].deadline);

  always_comb begin
    ctrl.cmd      = CELL_HOLD;
    ctrl.deadline = key_deadline;
    ctrl.handler  = key_handler;
    ctrl.argument = key_argument;
    unique case (state)
      S_START:  ctrl.cmd = full ? CELL_HOLD : CELL_INSERT;
      S_CANCEL: ctrl.cmd = CELL_REMOVE;
      S_CHECK:  ctrl.cmd = head_due ? CELL_POP : CELL_HOLD;
      default:  ctrl.cmd = CELL_HOLD;
    endcase
  end

  // the slot chain: data moves right on insert, left on removal
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    stq_entry_t left_entry;
    stq_entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_entry = EMPTY_ENTRY;
    end else begin : g_mid_left
      assign left_entry = chain[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign right_entry = EMPTY_ENTRY;
    end else begin : g_mid_right
      assign right_entry = chain[i+1];
    end

    stq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (left_entry),
      .right     (right_entry),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .entry     (chain[i])
    );

    assign valid_vec[i] = chain[i].valid;
  end

  // sequencer and registered result ports
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid     <= 1'b0;
      status           <= ST_OK;
      expired_handler  <= '0;
      expired_argument <= '0;
      last             <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key_deadline <= now + delay_ms;
            key_now      <= now;
            key_handler  <= handler_id;
            key_argument <= argument;
            unique case (operation)
              OP_START:  state <= S_START;
              OP_CANCEL: state <= S_CANCEL;
              OP_CHECK:  state <= S_CHECK;
              default:   state <= S_OTHER;
            endcase
          end
        end
        S_START: begin
          result_valid <= 1'b1;
          status       <= full ? ST_FULL : ST_OK;
          state        <= S_IDLE;
        end
        S_CANCEL, S_OTHER: begin
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        S_CHECK: begin
          if (head_due) begin
            // entries without a callback leave silently
            result_valid     <= chain[0].handler != '0;
            status           <= ST_EXPIRED;
            expired_handler  <= chain[0].handler;
            expired_argument <= chain[0].argument;
            last             <= 1'b0;
          end else begin
            result_valid <= 1'b1;
            status       <= ST_DONE;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the final result of a command always coincides with the sequencer back at idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy)
    else $error("final result while sequencer busy");

  // an expired result names a real callback and is never the final one
  a_expired_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_EXPIRED |-> !last && expired_handler != '0)
    else $error("malformed expired result");

  // occupied slots always form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + (ENTRIES + 1)'(1)))
    else $error("slot chain has a gap");

  // a full answer leaves every slot occupied
  a_full_answer: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_FULL |-> &valid_vec)
    else $error("table full reported with a free slot");

endmodule

### test/tb_sorted_timeout_queue.sv
// self-checking testbench for the sorted timeout queue: directed and random commands
module tb_sorted_timeout_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  // table depth, kept equal to the dut parameter
  localparam int SLOTS = 16;
  // the fourth operation code has no meaning; the block just answers ok
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // a time base just below the 32-bit wrap, so deadlines straddle zero
  localparam logic [31:0] WRAP_BASE = 32'hffff_fff0;
  // cycles allowed for the queue of expected results to drain
  localparam int DRAIN_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handler;
    logic [31:0] argument;
    logic        last;
  } timeout_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [31:0] now;
  logic [31:0] delay_ms;
  logic [15:0] handler_id;
  logic [31:0] argument;
  logic        result_valid;
  logic [1:0]  status;
  logic [15:0] expired_handler;
  logic [31:0] expired_argument;
  logic        last;

  // our own copy of the pending timeout table, entries 0 .. pending_count-1 in deadline order
  logic [31:0] pending_deadline [SLOTS];
  logic [15:0] pending_handler  [SLOTS];
  logic [31:0] pending_argument [SLOTS];
  int          pending_count = 0;

  // answers the block still owes, oldest first
  timeout_result_t expected_results [$];
  int              error_count = 0;
  bit              idle_gaps = 1'b1;
  logic [31:0]     time_base;

  sorted_timeout_queue #(
    .ENTRIES(SLOTS)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .now              (now),
    .delay_ms         (delay_ms),
    .handler_id       (handler_id),
    .argument         (argument),
    .result_valid     (result_valid),
    .status           (status),
    .expired_handler  (expired_handler),
    .expired_argument (expired_argument),
    .last             (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // timeout table predictor
  // ---------------------------------------------------------------------------

  // wraparound order: a is strictly earlier than b when a - b is negative as a signed word
  function automatic bit deadline_before(logic [31:0] a, logic [31:0] b);
    return $signed(a - b) < 0;
  endfunction

  function automatic void expect_answer(logic [1:0] st, logic [15:0] h, logic [31:0] a,
                                        logic l);
    timeout_result_t r;
    r.status   = st;
    r.handler  = h;
    r.argument = a;
    r.last     = l;
    expected_results.push_back(r);
  endfunction

  // close the gap left by a removed entry
  function automatic void drop_pending(int pos);
    int i;
    for (i = pos; i + 1 < pending_count; i++) begin
      pending_deadline[i] = pending_deadline[i + 1];
      pending_handler[i]  = pending_handler[i + 1];
      pending_argument[i] = pending_argument[i + 1];
    end
    pending_count--;
  endfunction

  // update the table for one accepted command and queue the answers it causes
  function automatic void update_timeouts(logic [1:0] op, logic [31:0] t, logic [31:0] dly,
                                          logic [15:0] hid, logic [31:0] arg);
    logic [31:0] due;
    logic [15:0] h;
    logic [31:0] a;
    int          pos;
    int          i;
    bit          found;
    case (op)
      OP_START: begin
        if (pending_count == SLOTS) begin
          expect_answer(ST_FULL, 16'd0, 32'd0, 1'b1);
        end else begin
          due = t + dly;
          // new entry goes behind every entry that is not strictly later
          pos = pending_count;
          found = 1'b0;
          for (i = 0; i < pending_count && !found; i++) begin
            if (deadline_before(due, pending_deadline[i])) begin
              pos = i;
              found = 1'b1;
            end
          end
          for (i = pending_count; i > pos; i--) begin
            pending_deadline[i] = pending_deadline[i - 1];
            pending_handler[i]  = pending_handler[i - 1];
            pending_argument[i] = pending_argument[i - 1];
          end
          pending_deadline[pos] = due;
          pending_handler[pos]  = hid;
          pending_argument[pos] = arg;
          pending_count++;
          expect_answer(ST_OK, 16'd0, 32'd0, 1'b1);
        end
      end
      OP_CANCEL: begin
        // first match in table order only; handler 0 matches like any id
        found = 1'b0;
        for (i = 0; i < pending_count && !found; i++) begin
          if (pending_handler[i] == hid && pending_argument[i] == arg) begin
            drop_pending(i);
            found = 1'b1;
          end
        end
        expect_answer(ST_OK, 16'd0, 32'd0, 1'b1);
      end
      OP_CHECK: begin
        while (pending_count > 0 && !deadline_before(t, pending_deadline[0])) begin
          h = pending_handler[0];
          a = pending_argument[0];
          drop_pending(0);
          // entries without a callback vanish silently
          if (h != 16'd0) expect_answer(ST_EXPIRED, h, a, 1'b0);
        end
        expect_answer(ST_DONE, 16'd0, 32'd0, 1'b1);
      end
      default: begin
        expect_answer(ST_OK, 16'd0, 32'd0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // command driver and result checker
  // ---------------------------------------------------------------------------

  // one command transfer; start stays high afterwards so the next command can follow
  // back to back, and is only lowered for an idle burst or at the end of a phase
  task automatic send_command(input logic [1:0] op, input logic [31:0] t,
                              input logic [31:0] dly, input logic [15:0] hid,
                              input logic [31:0] arg);
    int gap;
    gap = 0;
    if (idle_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    operation  <= op;
    now        <= t;
    delay_ms   <= dly;
    handler_id <= hid;
    argument   <= arg;
    // busy read right at the edge is the value the dut saw
    do @(posedge clk); while (busy);
    update_timeouts(op, t, dly, hid, arg);
  endtask

  // drop start, wait until every owed answer has come, then keep watching for stray results
  task automatic finish_phase();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
      expected_results.delete();
    end
    // leave room for stray results to show up
    repeat (24) @(posedge clk);
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // every strobed result is compared with the oldest answer still owed
  always @(posedge clk) begin
    timeout_result_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %h handler %h arg %h",
                 $time, status, expired_handler, expired_argument);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("expired_handler", 32'(want.handler), 32'(expired_handler));
        compare_field("expired_argument", want.argument, expired_argument);
        compare_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // ordering around the wrap, equal deadlines, and the cancel cases
  task automatic test_start_and_cancel();
    send_command(OP_START, WRAP_BASE, 32'd0, 16'd1, 32'd0);
    // deadline wraps past zero, so it is later than the first
    send_command(OP_START, WRAP_BASE, 32'h20, 16'd2, 32'hffff_ffff);
    // equal deadline lands behind the existing one
    send_command(OP_START, WRAP_BASE, 32'd0, 16'd0, 32'd5);
    // largest delay ends one tick before now, so it goes to the head
    send_command(OP_START, WRAP_BASE, 32'hffff_ffff, 16'hffff, 32'h1234_5678);
    // two identical entries, only the first of them should go on cancel
    send_command(OP_START, WRAP_BASE, 32'd5, 16'd7, 32'd7);
    send_command(OP_START, WRAP_BASE, 32'd5, 16'd7, 32'd7);
    // handler matches, argument does not: nothing removed
    send_command(OP_CANCEL, WRAP_BASE, 32'd0, 16'd2, 32'd0);
    // cancel of a handler 0 entry
    send_command(OP_CANCEL, WRAP_BASE, 32'hffff_ffff, 16'd0, 32'd5);
    send_command(OP_CANCEL, WRAP_BASE, 32'd0, 16'd7, 32'd7);
    finish_phase();
  endtask

  // fill every slot, one of them without a callback, then push one more
  task automatic test_table_full();
    bit first;
    first = 1'b1;
    while (pending_count < SLOTS) begin
      send_command(OP_START, WRAP_BASE, $urandom_range(0, 32'h100),
                   first ? 16'd0 : 16'($urandom_range(1, 16'hffff)), $urandom);
      first = 1'b0;
    end
    send_command(OP_START, WRAP_BASE, 32'd1, 16'd3, 32'd3);
    finish_phase();
  endtask

  // partial expiry at the wrap, then everything due, then a check of an empty table
  task automatic test_check_expiry();
    send_command(OP_CHECK, WRAP_BASE, 32'd0, 16'd0, 32'd0);
    send_command(OP_CHECK, 32'h0000_0200, $urandom, 16'($urandom), $urandom);
    send_command(OP_CHECK, 32'h0000_0200, 32'd0, 16'd0, 32'd0);
    finish_phase();
  endtask

  task automatic test_unused_operation();
    send_command(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    finish_phase();
  endtask

  // mostly well-formed traffic on a running millisecond clock, some of it pure noise
  task automatic test_random_traffic(input int count);
    logic [1:0]  op;
    logic [31:0] t;
    logic [31:0] dly;
    logic [15:0] hid;
    logic [31:0] arg;
    int          pick;
    int          slot;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      time_base += $urandom_range(0, 20);
      t   = time_base;
      dly = $urandom_range(0, 800);
      // few distinct ids and arguments so cancels and duplicates hit often
      hid = 16'($urandom_range(1, 8));
      arg = $urandom_range(0, 3);
      if (pick < 45) begin
        op = OP_START;
        case ($urandom_range(0, 9))
          0: dly = $urandom;
          1: dly = 32'd0;
          2: hid = 16'd0;
          3: begin
            hid = 16'($urandom);
            arg = $urandom;
          end
          default: ;
        endcase
      end else if (pick < 65) begin
        op = OP_CANCEL;
        // usually aim at a live entry, otherwise a likely miss
        if (pending_count > 0 && $urandom_range(0, 2) != 0) begin
          slot = $urandom_range(0, pending_count - 1);
          hid  = pending_handler[slot];
          arg  = pending_argument[slot];
        end
      end else if (pick < 90) begin
        op = OP_CHECK;
        time_base += $urandom_range(0, 150);
        t = time_base;
      end else begin
        // noise: any code, any field values, including far jumps of now
        op  = (pick < 95) ? OP_UNUSED : 2'($urandom_range(0, 3));
        t   = $urandom;
        dly = $urandom;
        hid = 16'($urandom);
        arg = $urandom;
      end
      send_command(op, t, dly, hid, arg);
    end
    finish_phase();
  endtask

  // last stretch with start held high, commands transfer as soon as busy drops
  task automatic test_back_to_back(input int count);
    idle_gaps = 1'b0;
    test_random_traffic(count);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    operation  = OP_START;
    now        = 32'd0;
    delay_ms   = 32'd0;
    handler_id = 16'd0;
    argument   = 32'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_start_and_cancel();
    test_table_full();
    test_check_expiry();
    test_unused_operation();
    time_base = $urandom;
    test_random_traffic(190);
    test_back_to_back(60);

    if (error_count == 0) begin
      $display("tb_sorted_timeout_queue passed");
    end else begin
      $display("tb_sorted_timeout_queue failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_sorted_timeout_queue failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/stq_pkg.sv
hw/rtl/stq_cell.sv
hw/rtl/sorted_timeout_queue.sv
test/tb_sorted_timeout_queue.sv
